FILE: rtl/sscr_pkg.sv
// Shared types, constants and helper functions for the substring case or replace block.
package sscr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE              = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES = 2'd3;

    typedef enum logic [1:0] {
        MODE_PASS    = 2'd0,
        MODE_UPPER   = 2'd1,
        MODE_LOWER   = 2'd2,
        MODE_REPLACE = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [3:0]  pattern_length;
        logic [63:0] pattern;
        logic [63:0] replacement;
    } cfg_t;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Transforms one matched byte; rep is the replacement byte at the same position.
    function automatic logic [7:0] xform(mode_t m, logic [7:0] c, logic [7:0] rep);
        logic [7:0] y;
        y = c;
        case (m)
            MODE_UPPER: begin
                if (c inside {[ASCII_LOWER_A:ASCII_LOWER_Z]}) y = c - CASE_OFFSET;
            end
            MODE_LOWER: begin
                if (c inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) y = c + CASE_OFFSET;
            end
            MODE_REPLACE: y = rep;
            default: y = c;
        endcase
        return y;
    endfunction

endpackage

FILE: rtl/stream_substring_case_or_replace_core.sv
// Top level of the streaming substring case change or replace block.
//
//  Channel   Ports                          Beat content
//  input     s_tvalid s_tready s_tdata      in_char, tlast = in_last
//  output    m_tvalid m_tready m_tdata      out_char, tlast = out_last
//  config    cfg_we cfg_index cfg_wdata     register write, no wait, no read-back
//
// The block takes one input byte per cycle while the burst queue has room. The window
// logic pushes the burst of an input beat into the queue in the cycle of the beat;
// the burst then waits in the burst queue and is registered in the output serializer.
// Bursts of up to MAX_PATTERN bytes (matches, released bytes, line ends) are queued
// (QUEUE_DEPTH bursts) and sent one byte per cycle while m_tready is high.
// s_tready drops only while the burst queue is full, which the output side sets.
// Reset (synchronous, active low) clears the configuration, the window count and
// the queue; the window bytes themselves are not cleared.
module stream_substring_case_or_replace_core import sscr_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] in_char
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] out_char
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int QW = MAX_PATTERN * 8 + CW + 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    cfg_t cfg_reg;

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:              cfg_reg.mode           <= mode_t'(cfg_wdata[1:0]);
                CFG_PATTERN_LENGTH:    cfg_reg.pattern_length <= cfg_wdata[3:0];
                CFG_PATTERN_BYTES:     cfg_reg.pattern        <= cfg_wdata[63:0];
                CFG_REPLACEMENT_BYTES: cfg_reg.replacement    <= cfg_wdata[63:0];
                default: ;
            endcase
        end
    end

    logic                     push;
    logic [MAX_PATTERN*8-1:0] push_bytes;
    logic [CW-1:0]            push_count;
    logic                     push_last;
    logic [CW-1:0]            win_count;
    logic                     pop;
    logic [QW-1:0]            q_data;
    logic                     q_full;
    logic                     q_empty;
    logic [LW-1:0]            q_level;

    // Front end: the window and the match decision, one beat per cycle while the queue is not full.
    sscr_front #(.P(MAX_PATTERN)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_tvalid),
        .s_char     (s_tdata),
        .s_last     (s_tlast),
        .s_ready    (s_tready),
        .q_full     (q_full),
        .push       (push),
        .push_bytes (push_bytes),
        .push_count (push_count),
        .push_last  (push_last),
        .win_count  (win_count)
    );

    // Each queue entry is one burst: bytes, their count and the line-end flag.
    sscr_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_last, push_count, push_bytes}),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty),
        .level     (q_level)
    );

    // Back end: serializes bursts onto the output channel.
    sscr_back #(.P(MAX_PATTERN)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_level != LW'(QUEUE_DEPTH)))
        else $error("burst pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_level != '0))
        else $error("burst popped from an empty queue");

    // Between beats the window holds fewer bytes than its depth.
    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        win_count < CW'(MAX_PATTERN))
        else $error("window count out of range");

    // A pushed burst always carries at least one byte, never more than the window.
    a_burst_size: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_count != '0) && (push_count <= CW'(MAX_PATTERN)))
        else $error("bad burst size");

endmodule

FILE: rtl/sscr_front.sv
// Front end: holds the byte window, finds matches and forms at most one burst of bytes per beat.
module sscr_front import sscr_pkg::*; #(
    parameter int P = MAX_PATTERN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfg_t                        cfg,
    input  logic                        s_valid,
    input  logic [7:0]                  s_char,
    input  logic                        s_last,
    output logic                        s_ready,
    input  logic                        q_full,
    output logic                        push,
    output logic [P*8-1:0]              push_bytes,
    output logic [$clog2(P+1)-1:0]      push_count,
    output logic                        push_last,
    output logic [$clog2(P+1)-1:0]      win_count
);

    localparam int CW = $clog2(P + 1);
    localparam int SW = CW + 1;

    logic [7:0]    win_reg [P];
    logic [7:0]    win_next [P];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic [7:0]    a [P];
    logic [7:0]    s [P];
    logic [7:0]    t [P];
    logic [7:0]    b [P];
    logic          matching;
    logic          full;
    logic          hit;
    logic          accept;
    logic [CW-1:0] len;
    logic [CW-1:0] n;
    logic [CW-1:0] e;
    logic [CW-1:0] m;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign win_count = cnt_reg;

    always_comb begin
        matching = (cfg.mode != MODE_PASS) && (cfg.pattern_length != 4'd0)
                   && (int'(cfg.pattern_length) <= P);
        len  = matching ? CW'(cfg.pattern_length) : CW'(1);
        n    = cnt_reg + CW'(1);
        full = (n >= len);
        e    = n - len;

        // Held bytes followed by the new byte, oldest first.
        for (int j = 0; j < P; j++) begin
            a[j] = (CW'(j) < cnt_reg) ? win_reg[j] : s_char;
        end

        // The candidate match starts right after the excess bytes.
        for (int i = 0; i < P; i++) begin
            s[i] = 8'h00;
            for (int j = 0; j < P; j++) begin
                if (SW'(j) == {1'b0, e} + SW'(i)) s[i] = a[j];
            end
            t[i] = xform(cfg.mode, s[i], cfg.replacement[8*i +: 8]);
        end

        hit = matching && full;
        for (int i = 0; i < P; i++) begin
            if ((CW'(i) < len) && (s[i] != cfg.pattern[8*i +: 8])) hit = 1'b0;
        end

        if (s_last)     m = n;
        else if (!full) m = '0;
        else if (hit)   m = n;
        else            m = e + CW'(1);

        for (int j = 0; j < P; j++) begin
            b[j] = a[j];
            if (hit) begin
                for (int i = 0; i < P; i++) begin
                    if (SW'(j) == {1'b0, e} + SW'(i)) b[j] = t[i];
                end
            end
            push_bytes[8*j +: 8] = b[j];
        end

        for (int i = 0; i < P; i++) begin
            win_next[i] = win_reg[i];
            for (int j = 0; j < P; j++) begin
                if (SW'(j) == {1'b0, m} + SW'(i)) win_next[i] = a[j];
            end
        end
        cnt_next = n - m;
    end

    assign push       = accept && (m != '0);
    assign push_count = m;
    assign push_last  = s_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < P; i++) win_reg[i] <= win_next[i];
        end
    end

endmodule

FILE: rtl/sscr_queue.sv
// Short queue of bursts between the front end and the output serializer.
module sscr_queue import sscr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [WIDTH-1:0]            push_data,
    input  logic                        pop,
    output logic [WIDTH-1:0]            pop_data,
    output logic                        full,
    output logic                        empty,
    output logic [$clog2(DEPTH+1)-1:0]  level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [LW-1:0]    level_reg;

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (level_reg == LW'(DEPTH));
    assign empty    = (level_reg == '0);
    assign level    = level_reg;

    function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)      level_reg <= level_reg + LW'(1);
            else if (pop && !push) level_reg <= level_reg - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/sscr_back.sv
// Back end: takes bursts from the queue and sends them out one byte per beat.
module sscr_back import sscr_pkg::*; #(
    parameter int P = MAX_PATTERN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    input  logic [P*8+$clog2(P+1):0]              q_data,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,
    output logic                                  m_tlast
);

    localparam int CW = $clog2(P + 1);

    logic [P*8-1:0] bytes_reg;
    logic [CW-1:0]  count_reg;
    logic           last_reg;
    logic [CW-1:0]  idx_reg;
    logic           valid_reg;
    logic           at_end;

    assign at_end   = (idx_reg == count_reg - CW'(1));
    assign pop      = !q_empty && (!valid_reg || (m_tready && at_end));
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg && at_end;

    always_comb begin
        m_tdata = 8'h00;
        for (int j = 0; j < P; j++) begin
            if (idx_reg == CW'(j)) m_tdata = bytes_reg[8*j +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (at_end) valid_reg <= 1'b0;
            else        idx_reg   <= idx_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            bytes_reg <= q_data[P*8-1:0];
            count_reg <= q_data[P*8 +: CW];
            last_reg  <= q_data[P*8+CW];
        end
    end

endmodule

FILE: dv/substring_filter_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the filtered byte stream of the substring block.
module substring_filter_checker import sscr_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] in_char
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [7:0]             m_tdata,   // [7:0] out_char
    input  logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     mismatches,
    output int                     waiting,
    output int                     matches_seen,
    output int                     beats_checked
);

    // Expected output beats, oldest first; characters and end-of-line flags in step.
    logic [7:0] expected_chars[$];
    bit         expected_lasts[$];

    mode_t       cur_mode;
    logic [3:0]  cur_len;
    logic [63:0] cur_pat;
    logic [63:0] cur_rep;

    logic [7:0] held[MAX_PATTERN_DEF];
    int         held_count;

    initial begin
        mismatches    = 0;
        waiting       = 0;
        matches_seen  = 0;
        beats_checked = 0;
        held_count    = 0;
        cur_mode      = MODE_PASS;
        cur_len       = '0;
        cur_pat       = '0;
        cur_rep       = '0;
    end

    function automatic logic [7:0] rewrite_byte(logic [7:0] c, int pos);
        logic [7:0] y;
        y = c;
        if (cur_mode == MODE_UPPER && c >= 8'h61 && c <= 8'h7a) begin
            y = c - 8'd32;
        end else if (cur_mode == MODE_LOWER && c >= 8'h41 && c <= 8'h5a) begin
            y = c + 8'd32;
        end else if (cur_mode == MODE_REPLACE) begin
            y = cur_rep[pos*8 +: 8];
        end
        return y;
    endfunction

    task automatic push_char(logic [7:0] c);
        expected_chars.push_back(c);
        expected_lasts.push_back(1'b0);
    endtask

    task automatic release_oldest();
        push_char(held[0]);
        for (int i = 1; i < MAX_PATTERN_DEF; i++) held[i-1] = held[i];
        held_count--;
    endtask

    // One accepted text byte: shift it into the window and queue what it lets out.
    task automatic absorb_text_byte(logic [7:0] c, logic line_end);
        logic matching;
        logic hit;
        int   len;
        int   queued_before;
        matching = cur_mode != MODE_PASS && cur_len != 0 && cur_len <= MAX_PATTERN_DEF;
        len = matching ? int'(cur_len) : 1;
        queued_before = expected_chars.size();
        // A shorter window after a setting change pushes out the oldest bytes first.
        while (held_count >= len) release_oldest();
        held[held_count] = c;
        held_count++;
        if (held_count == len) begin
            hit = matching;
            for (int i = 0; i < len; i++) begin
                if (held[i] != cur_pat[i*8 +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (int i = 0; i < len; i++) push_char(rewrite_byte(held[i], i));
                held_count = 0;
                matches_seen++;
            end else begin
                release_oldest();
            end
        end
        if (line_end) begin
            while (held_count > 0) release_oldest();
            if (expected_chars.size() > queued_before) begin
                expected_lasts[expected_lasts.size() - 1] = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        logic [7:0] want_char;
        bit         want_last;
        if (!aresetn) begin
            cur_mode   = MODE_PASS;
            cur_len    = '0;
            cur_pat    = '0;
            cur_rep    = '0;
            held_count = 0;
            expected_chars.delete();
            expected_lasts.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MODE:              cur_mode = mode_t'(cfg_wdata[1:0]);
                    CFG_PATTERN_LENGTH:    cur_len  = cfg_wdata[3:0];
                    CFG_PATTERN_BYTES:     cur_pat  = cfg_wdata[63:0];
                    CFG_REPLACEMENT_BYTES: cur_rep  = cfg_wdata[63:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) absorb_text_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output beat, expected none, got char %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want_char = expected_chars.pop_front();
                    want_last = expected_lasts.pop_front();
                    if (m_tdata !== want_char) begin
                        mismatches++;
                        $display("%0t: out_char expected %h got %h", $time, want_char, m_tdata);
                    end
                    if (m_tlast !== want_last) begin
                        mismatches++;
                        $display("%0t: out_last expected %b got %b", $time, want_last, m_tlast);
                    end
                    beats_checked++;
                end
            end
        end
        waiting = expected_chars.size();
    end

endmodule

FILE: dv/stream_substring_case_or_replace_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the substring case change or replace block: stimulus and verdict.
module stream_substring_case_or_replace_core_tb import sscr_pkg::*;;

    // The run is bounded by a cycle count far above the slowest legal run:
    // roughly 900 beats, each behind a long sender gap and a long receiver stall.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 420;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [7:0] in_char
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;   // [7:0] out_char
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int mismatches;
    int waiting;
    int matches_seen;
    int beats_checked;

    // Stimulus bookkeeping for the closing summary.
    int bytes_sent;
    int lines_sent;
    int settings_used;
    int cycles;

    // Idling switches; some phases run with one side at full rate.
    bit tx_gaps;
    bit rx_stalls;

    // Copy of the current pattern setting, used to plant matches in the text.
    logic [3:0]  set_len;
    logic [63:0] set_pat;

    stream_substring_case_or_replace_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    substring_filter_checker filter_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .waiting       (waiting),
        .matches_seen  (matches_seen),
        .beats_checked (beats_checked)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Text drawn from a small pool makes chance matches likely; it holds letters of
    // both cases and a few punctuation bytes that case modes must leave alone.
    function automatic logic [7:0] pool_byte();
        case ($urandom_range(0, 7))
            0: return "a";
            1: return "Z";
            2: return "q";
            3: return "M";
            4: return "^";
            5: return "_";
            6: return "%";
            default: return "-";
        endcase
    endfunction

    // While rx_stalls is set, the receiver alternates ready runs with stalls of random length, so stalls
    // land on every phase of a burst, including the middle of a match.
    initial begin
        int run;
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            run = $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            if (rx_stalls) begin
                stall = idle_length();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: a run that hangs is a failure.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** stream_substring_case_or_replace_core: FAILED **");
        $finish;
    end

    // Sends one text byte. Valid stays high from one beat to the next unless a gap
    // is drawn, so back-to-back beats never lower and raise valid in one step.
    task automatic send_beat(logic [7:0] c, logic line_end);
        int gap;
        gap = tx_gaps ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= line_end;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (line_end) lines_sent++;
    endtask

    task automatic send_text(string s, bit line_end);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], line_end && i == s.len() - 1);
    endtask

    // Stops the sender until every predicted beat has come out, then lets the
    // window logic settle; bytes still held in the window produce
    // no beat, so this is the only way to know the block is quiet.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (waiting != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Writes all four registers on consecutive cycles. Only call while quiet.
    task automatic program_regs(mode_t m, logic [3:0] len, logic [63:0] pat,
                                logic [63:0] rep);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_wdata <= CFG_DATA_W'(m);
        @(posedge aclk);
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_wdata <= CFG_DATA_W'(len);
        @(posedge aclk);
        cfg_index <= CFG_PATTERN_BYTES;
        cfg_wdata <= pat;
        @(posedge aclk);
        cfg_index <= CFG_REPLACEMENT_BYTES;
        cfg_wdata <= rep;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        set_len = len;
        set_pat = pat;
        settings_used++;
    endtask

    // Chooses a register setting for a random phase. The first few phases pin the
    // extremes; later ones are random, including lengths above the window size
    // that must disable matching, and pass-through with a live pattern.
    task automatic pick_settings(int phase, output mode_t m, output logic [3:0] len,
                                 output logic [63:0] pat, output logic [63:0] rep);
        int r;
        for (int i = 0; i < 8; i++) begin
            pat[i*8 +: 8] = ($urandom_range(0, 9) < 7) ? pool_byte()
                                                       : 8'($urandom_range(0, 255));
        end
        rep = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r == 0) len = 4'd0;
        else if (r == 1) len = 4'($urandom_range(9, 15));
        else if (r < 4) len = 4'd8;
        else len = 4'($urandom_range(1, 8));
        m = mode_t'($urandom_range(0, 3));
        case (phase)
            0: begin
                m   = MODE_REPLACE;
                len = 4'd8;
                pat = '1;
                rep = '0;
            end
            1: begin
                m   = MODE_UPPER;
                len = 4'd15;
            end
            2: begin
                m   = MODE_LOWER;
                len = 4'd1;
            end
            3: begin
                m   = MODE_PASS;
                len = 4'd3;
            end
            4: begin
                m   = MODE_REPLACE;
                len = 4'd1;
                rep = '1;
            end
            default: ;
        endcase
    endtask

    // Sends a line of n bytes. About a third of the positions start a copy of the
    // pattern, whole or cut short, so matches, near misses and overlapping
    // candidates are all common.
    task automatic send_line(int n, bit line_end);
        int i;
        int r;
        int plen;
        int k;
        plen = (set_len > 8) ? 8 : int'(set_len);
        i = 0;
        while (i < n) begin
            r = $urandom_range(0, 99);
            if (r < 35 && plen > 0) begin
                k = (r < 25) ? plen : $urandom_range(1, plen);
                for (int j = 0; j < k && i < n; j++) begin
                    send_beat(set_pat[j*8 +: 8], line_end && i == n - 1);
                    i++;
                end
            end else begin
                send_beat((r < 70) ? pool_byte() : 8'($urandom_range(0, 255)),
                          line_end && i == n - 1);
                i++;
            end
        end
    endtask

    initial begin
        mode_t       m;
        logic [3:0]  len;
        logic [63:0] pat;
        logic [63:0] rep;
        int          phase;
        int          budget;
        int          line_len;
        int          target;
        bit          close_line;

        bytes_sent    = 0;
        lines_sent    = 0;
        settings_used = 0;
        set_len       = '0;
        set_pat       = '0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // Out of reset matching is off: both byte extremes go straight through.
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b1);

        // Uppercase a three-byte match; the unmatched lead byte leaves alone and the
        // trailing byte is flushed at the line end with the end flag.
        wait_drained();
        program_regs(MODE_UPPER, 4'd3, 64'h0000_0000_0063_6261, '0);
        send_text("zabcA", 1'b1);

        // Lowercase a match that also holds a non-letter, which must not change.
        wait_drained();
        program_regs(MODE_LOWER, 4'd2, 64'h0000_0000_0000_255a, '0);
        send_text("Z%Z", 1'b1);

        // Full-width replacement with extreme byte values on both sides, the match
        // ending exactly on the line end.
        wait_drained();
        pat = 64'hff00_7f80_0102_0304;
        program_regs(MODE_REPLACE, 4'd8, pat, 64'h5e5f_252d_0000_ffff);
        for (int i = 0; i < 8; i++) send_beat(pat[i*8 +: 8], i == 7);

        // Setting change in the middle of a line: five bytes sit in the wide window,
        // then the window shrinks to two and the excess must leave unchanged.
        send_text("xxxxx", 1'b0);
        wait_drained();
        program_regs(MODE_UPPER, 4'd2, 64'h0000_0000_0000_7979, '0);
        send_text("y", 1'b1);

        // Random part: phases of random lines under one setting each. Every phase
        // change waits for the block to drain, and sometimes the last line of a
        // phase is left open so that the new setting meets held bytes.
        target = bytes_sent + RANDOM_ITEMS;
        phase  = 0;
        while (bytes_sent < target) begin
            wait_drained();
            pick_settings(phase, m, len, pat, rep);
            program_regs(m, len, pat, rep);
            tx_gaps   = (phase % 4) != 1;
            rx_stalls = (phase % 4) != 2;
            budget = $urandom_range(20, 60);
            while (budget > 0) begin
                line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 12);
                if (line_len > budget) line_len = budget;
                budget -= line_len;
                close_line = !(budget == 0 && $urandom_range(0, 3) == 0);
                send_line(line_len, close_line);
            end
            phase++;
        end

        // Close the last line so every held byte comes out, then drain.
        tx_gaps = 1'b1;
        send_beat(pool_byte(), 1'b1);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (waiting != 0);
        repeat (20) @(posedge aclk);
        @(negedge aclk);

        $display("Run covered %0d text bytes in %0d lines under %0d register settings.",
                 bytes_sent, lines_sent, settings_used);
        $display("%0d pattern matches were rewritten and %0d output beats were checked.",
                 matches_seen, beats_checked);
        if (mismatches == 0) begin
            $display("** stream_substring_case_or_replace_core: PASSED **");
        end else begin
            $display("** stream_substring_case_or_replace_core: FAILED **");
        end
        $finish;
    end

endmodule
